@@ hdl/rrb_pkg.sv @@
// Shared constants, types and codes for the report receive ring.
`default_nettype none
package rrb_pkg;

	localparam int RING_DEPTH   = 512;
	localparam int REPORT_BYTES = 64;
	localparam int QUEUE_DEPTH  = 2;

	localparam int PTR_W  = $clog2(RING_DEPTH);
	localparam int POS_W  = $clog2(REPORT_BYTES);
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int LEN_W  = 6;
	localparam int FILL_W = 9;
	localparam int ADDR_W = 3;

	localparam logic [LEN_W-1:0] LEN_MAX     = LEN_W'(REPORT_BYTES - 2);
	localparam int               CTRL_BIT    = 6;
	localparam logic [7:0]       BOOT_CODE   = 8'hB5;
	localparam logic [7:0]       HOST_RESET  = 8'hB6;
	localparam logic [7:0]       MATCH_ID_RESET = 8'hB6;

	// Register indexes on the configuration port.
	localparam logic REG_MATCH_ID  = 1'b0;
	localparam logic REG_HOST_MODE = 1'b1;

	// Control codes reported with each result.
	localparam logic [1:0] CODE_NONE  = 2'd0;
	localparam logic [1:0] CODE_BOOT  = 2'd1;
	localparam logic [1:0] CODE_RESET = 2'd2;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_WRITE,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic [1:0] code;
	} qent_t;

endpackage
`default_nettype wire

@@ hdl/rrb_front.sv @@
// Report deframer: tracks the byte position and classifies each accepted word.
`default_nettype none
module rrb_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic          cmd,
	input  wire logic [7:0]    rx_byte,
	input  wire logic          last_byte,
	input  wire logic [7:0]    match_id,
	input  wire logic          host_mode,
	output rrb_pkg::qent_t     ent
);
	import rrb_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic             good_q;
	logic             ctrl_q;
	logic [LEN_W-1:0] len_q;

	logic [POS_W-1:0] pos_m2;
	logic [LEN_W-1:0] len_raw;

	assign pos_m2  = pos_q - POS_W'(2);
	assign len_raw = rx_byte[LEN_W-1:0];

	// Classify the word against the current deframer state.
	always_comb begin
		ent.op   = OP_NONE;
		ent.data = rx_byte;
		ent.code = CODE_NONE;
		if (cmd) begin
			ent.op = OP_READ;
		end else if (pos_q != '0 && good_q && pos_q != POS_W'(1)) begin
			if (ctrl_q) begin
				if (pos_q == POS_W'(2)) begin
					if (host_mode) begin
						if (rx_byte == BOOT_CODE)
							ent.code = CODE_BOOT;
						else if (rx_byte == HOST_RESET)
							ent.code = CODE_RESET;
					end else if (rx_byte == match_id) begin
						ent.code = CODE_RESET;
					end
				end
			end else if (pos_m2 < len_q) begin
				ent.op = OP_WRITE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			good_q <= 1'b0;
			ctrl_q <= 1'b0;
			len_q  <= '0;
		end else if (accept && !cmd) begin
			if (pos_q == '0) begin
				good_q <= (rx_byte == match_id);
				ctrl_q <= 1'b0;
				len_q  <= '0;
			end else if (good_q && pos_q == POS_W'(1)) begin
				ctrl_q <= rx_byte[CTRL_BIT];
				len_q  <= (len_raw > LEN_MAX) ? LEN_MAX : len_raw;
			end
			if (last_byte || pos_q == POS_W'(REPORT_BYTES - 1))
				pos_q <= '0;
			else
				pos_q <= pos_q + POS_W'(1);
		end
	end

endmodule
`default_nettype wire

@@ hdl/rrb_queue.sv @@
// Short queue of classified words between the deframer and the ring.
`default_nettype none
module rrb_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire rrb_pkg::qent_t push_ent,
	input  wire logic           pop,
	output logic                full,
	output logic                not_empty,
	output rrb_pkg::qent_t      head_ent
);
	import rrb_pkg::*;

	qent_t             ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full      = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head_ent  = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_q] <= push_ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
			if (pop)
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

endmodule
`default_nettype wire

@@ hdl/rrb_back.sv @@
// Ring storage with head and tail pointers and the result register.
`default_nettype none
module rrb_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	input  wire rrb_pkg::qent_t q_ent,
	output logic                pop,
	input  wire logic           out_stall,
	output logic                out_valid,
	output logic [7:0]          read_data,
	output logic                read_valid,
	output logic [8:0]          fill_level,
	output logic [1:0]          control_code
);
	import rrb_pkg::*;

	logic [7:0]       ring_mem [RING_DEPTH];
	logic [7:0]       rd_data_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic             out_valid_q;
	logic             rvalid_q;
	logic [FILL_W-1:0] fill_q;
	logic [1:0]       code_q;

	logic             wr_en;
	logic             rd_en;
	logic [PTR_W-1:0] head_n;
	logic [PTR_W-1:0] tail_n;
	logic [PTR_W:0]   fill_n;

	assign pop   = q_valid && (!out_valid_q || !out_stall);
	assign wr_en = pop && q_ent.op == OP_WRITE;
	assign rd_en = pop && q_ent.op == OP_READ && head_q != tail_q;

	always_comb begin
		head_n = head_q;
		tail_n = tail_q;
		if (wr_en)
			head_n = (head_q == PTR_W'(RING_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
		if (rd_en)
			tail_n = (tail_q == PTR_W'(RING_DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);
		if (head_n >= tail_n)
			fill_n = {1'b0, head_n} - {1'b0, tail_n};
		else
			fill_n = {1'b0, head_n} + (PTR_W+1)'(RING_DEPTH) - {1'b0, tail_n};
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			ring_mem[head_q] <= q_ent.data;
		if (rd_en)
			rd_data_q <= ring_mem[tail_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			out_valid_q <= 1'b0;
			rvalid_q    <= 1'b0;
			fill_q      <= '0;
			code_q      <= CODE_NONE;
		end else begin
			head_q <= head_n;
			tail_q <= tail_n;
			if (pop) begin
				out_valid_q <= 1'b1;
				rvalid_q    <= rd_en;
				fill_q      <= FILL_W'(fill_n);
				code_q      <= q_ent.code;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign read_valid   = rvalid_q;
	assign read_data    = rvalid_q ? rd_data_q : 8'd0;
	assign fill_level   = fill_q;
	assign control_code = code_q;

	a_read_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && rvalid_q |-> code_q == CODE_NONE)
		else $error("read result carries a control code");

	a_tail_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		!rd_en |=> $stable(tail_q))
		else $error("tail moved without a read");

	a_head_steps: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && head_q != PTR_W'(RING_DEPTH - 1) |=> head_q == $past(head_q) + PTR_W'(1))
		else $error("head did not advance on a write");

	a_no_read_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> head_q != tail_q)
		else $error("read issued on an empty ring");

endmodule
`default_nettype wire

@@ hdl/hid_report_rx_ring_buffer_unit.sv @@
// Top level of the report receive ring: configuration port, deframer, queue and ring.
`default_nettype none
// An accepted word is registered in the queue, then in the result register unless it stalls.
// Throughput: one word per cycle unless stalled, set by the single ring port's write or read.
// The two-entry queue lets the deframer take up to two words while the result is stalled.
// Reset: pointers, deframer state, queue and result register clear asynchronously.
// The ring contents are not cleared; no entry can be read before it has been written.
module hid_report_rx_ring_buffer_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// Input words.
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        cmd,
	input  wire logic [7:0]                  rx_byte,
	input  wire logic                        last_byte,
	// Result words.
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [7:0]                       read_data,
	output logic                             read_valid,
	output logic [8:0]                       fill_level,
	output logic [1:0]                       control_code,
	// Configuration port.
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [rrb_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	import rrb_pkg::*;

	logic [7:0] match_id_q;
	logic       host_mode_q;
	logic       in_accept;
	logic       cfg_write;
	logic       q_full;
	logic       q_valid;
	logic       q_pop;
	qent_t      front_ent;
	qent_t      q_head;

	// The register index is the word address; byte lanes below it are ignored.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_id_q  <= MATCH_ID_RESET;
			host_mode_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (paddr[2])
				REG_MATCH_ID:  match_id_q  <= pwdata[7:0];
				REG_HOST_MODE: host_mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MATCH_ID:  prdata = {24'd0, match_id_q};
			REG_HOST_MODE: prdata = {31'd0, host_mode_q};
			default:       prdata = 32'd0;
		endcase
	end

	// A word is taken whenever the queue has room, and the input stalls only while it is full.
	assign in_stall  = q_full;
	assign in_accept = in_valid && !q_full;

	rrb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_accept),
		.cmd       (cmd),
		.rx_byte   (rx_byte),
		.last_byte (last_byte),
		.match_id  (match_id_q),
		.host_mode (host_mode_q),
		.ent       (front_ent)
	);

	// Every accepted word yields one result, so every word enters the queue.
	rrb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_accept),
		.push_ent  (front_ent),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_valid),
		.head_ent  (q_head)
	);

	rrb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_ent        (q_head),
		.pop          (q_pop),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.read_data    (read_data),
		.read_valid   (read_valid),
		.fill_level   (fill_level),
		.control_code (control_code)
	);

endmodule
`default_nettype wire
